>>> hw/rtl/ipv4_range_group_match_unit_defines.svh
`ifndef IPV4_RANGE_GROUP_MATCH_UNIT_DEFINES_SVH
`define IPV4_RANGE_GROUP_MATCH_UNIT_DEFINES_SVH

// Check cons in the same cycle as ante
`define IRGM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define IRGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/irgm_pkg.sv
package irgm_pkg;

  localparam int unsigned CNT_W          = 7;
  localparam int unsigned IDX_W          = 6;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned DEF_MAX_RANGES = 64;
  localparam int unsigned OR_GRP         = 16;
  localparam int unsigned APB_AW         = 3;
  localparam int unsigned APB_DW         = 32;
  localparam int unsigned S_TDATA_W      = 104;
  localparam int unsigned M_TDATA_W      = 8;

  localparam logic REG_RANGE_COUNT = 1'b0;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_MATCH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] range_high;
    logic [ADDR_W-1:0] range_low;
    logic [IDX_W-1:0]  entry_index;
    cmd_e              command;
  } item_t;

endpackage

>>> hw/rtl/irgm_cfg.sv
module irgm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [irgm_pkg::APB_AW-1:0]  paddr,
  input  logic [irgm_pkg::APB_DW-1:0]  pwdata,
  output logic [irgm_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output logic [irgm_pkg::CNT_W-1:0]   range_count_o
);
  import irgm_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             sel_count;

  assign sel_count = (paddr[2] == REG_RANGE_COUNT);

  always_comb begin
    count_d = count_q;
    if (psel && penable && pwrite && sel_count) begin
      count_d = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign prdata        = sel_count ? APB_DW'(count_q) : '0;
  assign pready        = 1'b1;
  assign range_count_o = count_q;

endmodule

>>> hw/rtl/irgm_lanes.sv
`include "ipv4_range_group_match_unit_defines.svh"

module irgm_lanes #(
  parameter int unsigned MAX_RANGES = irgm_pkg::DEF_MAX_RANGES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  irgm_pkg::item_t            in_item_i,
  input  logic [irgm_pkg::CNT_W-1:0] range_count_i,
  output logic                       hit_valid_o,
  input  logic                       hit_ready_i,
  output logic [MAX_RANGES-1:0]      hit_o
);
  import irgm_pkg::*;

  logic [ADDR_W-1:0]     low_q  [MAX_RANGES];
  logic [ADDR_W-1:0]     high_q [MAX_RANGES];
  logic [MAX_RANGES-1:0] we;
  logic [MAX_RANGES-1:0] hit_d, hit_q;
  logic                  v_q, v_d;
  logic                  ld, take, is_wr;

  assign ld         = ~v_q | hit_ready_i;
  assign in_ready_o = ld;
  assign take       = in_valid_i & ld;
  assign is_wr      = take & (in_item_i.command == CMD_WRITE);

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_lane
    assign we[i] = is_wr & (int'(in_item_i.entry_index) == i);

    always_ff @(posedge clk_i) begin
      if (we[i]) begin
        low_q[i]  <= in_item_i.range_low;
        high_q[i] <= in_item_i.range_high;
      end
    end

    assign hit_d[i] = (i < int'(range_count_i))
                    & (in_item_i.address >= low_q[i])
                    & (in_item_i.address <= high_q[i]);
  end

  always_comb begin
    v_d = v_q;
    if (ld) begin
      v_d = in_valid_i & (in_item_i.command == CMD_MATCH);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      hit_q <= hit_d;
    end
  end

  assign hit_valid_o = v_q;
  assign hit_o       = hit_q;

  `IRGM_ASSERT_NEXT(a_write_gives_no_result, take && in_item_i.command == CMD_WRITE, !v_q, "write request produced a result")
  `IRGM_ASSERT_NEXT(a_empty_table_no_hit, take && range_count_i == '0, hit_q == '0, "hit with empty table")
  `IRGM_ASSERT_SAME(a_single_lane_write, 1'b1, $onehot0(we), "more than one entry written")

endmodule

>>> hw/rtl/irgm_reduce.sv
`include "ipv4_range_group_match_unit_defines.svh"

module irgm_reduce #(
  parameter int unsigned MAX_RANGES = irgm_pkg::DEF_MAX_RANGES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  hit_valid_i,
  output logic                  hit_ready_o,
  input  logic [MAX_RANGES-1:0] hit_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_matched_o
);
  import irgm_pkg::*;

  localparam int unsigned NG1 = (MAX_RANGES + OR_GRP - 1) / OR_GRP;
  localparam int unsigned NG2 = (NG1 + OR_GRP - 1) / OR_GRP;

  logic [NG1*OR_GRP-1:0] hit_pad;
  logic [NG2*OR_GRP-1:0] g1_pad;
  logic [NG1-1:0]        g1_d, g1_q;
  logic [NG2-1:0]        g2_d, g2_q;
  logic                  v3_q, v4_q, out_v_q, matched_q;
  logic                  ld3, ld4, ld_out;

  assign ld_out      = ~out_v_q | out_ready_i;
  assign ld4         = ~v4_q | ld_out;
  assign ld3         = ~v3_q | ld4;
  assign hit_ready_o = ld3;

  assign hit_pad = (NG1*OR_GRP)'(hit_i);
  assign g1_pad  = (NG2*OR_GRP)'(g1_q);

  for (genvar j = 0; j < NG1; j++) begin : g_or1
    assign g1_d[j] = |hit_pad[j*OR_GRP +: OR_GRP];
  end

  for (genvar k = 0; k < NG2; k++) begin : g_or2
    assign g2_d[k] = |g1_pad[k*OR_GRP +: OR_GRP];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ld3) begin
        v3_q <= hit_valid_i;
      end
      if (ld4) begin
        v4_q <= v3_q;
      end
      if (ld_out) begin
        out_v_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      g1_q <= g1_d;
    end
    if (ld4) begin
      g2_q <= g2_d;
    end
    if (ld_out) begin
      matched_q <= |g2_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign out_matched_o = matched_q;

  `IRGM_ASSERT_NEXT(a_first_level, ld3 && hit_valid_i, v3_q && ((|g1_q) == $past(|hit_i)), "first OR level lost a hit")
  `IRGM_ASSERT_NEXT(a_second_level, ld4 && v3_q, v4_q && ((|g2_q) == $past(|g1_q)), "second OR level lost a hit")
  `IRGM_ASSERT_NEXT(a_result_load, ld_out && v4_q, out_v_q && (matched_q == $past(|g2_q)), "result register mismatch")

endmodule

>>> hw/rtl/ipv4_range_group_match_unit.sv
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid_i/s_axis_tready_o tdata: entry_index, range_low, range_high,
//                                                address; tuser: command
// m_axis    out  m_axis_tvalid_o/m_axis_tready_i tdata: matched
// apb       in   psel/penable/pwrite/pready      paddr, pwdata, prdata: range_count
//
// One request enters per cycle while the stages ahead do not stall; a match result is
// registered by the input stage, the row of per-entry compares and the two-level OR tree
// with its output register. Write requests update the table as they pass the
// compare row and produce no result.
// Reset clears valid bits and range_count only; table entries are undefined until written.
// A stall on m_axis holds each full stage whose later stages are all full; the rest still advance.
module ipv4_range_group_match_unit #(
  parameter int unsigned MAX_RANGES = irgm_pkg::DEF_MAX_RANGES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // entry_index[5:0], range_low[37:6], range_high[69:38], address[101:70], zero pad
  input  logic [irgm_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // command[0]
  input  logic [0:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // matched[0], zero pad
  output logic [irgm_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [irgm_pkg::APB_AW-1:0]     paddr,
  input  logic [irgm_pkg::APB_DW-1:0]     pwdata,
  output logic [irgm_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);
  import irgm_pkg::*;

  item_t                 in_item;
  item_t                 item_q;
  logic                  v1_q;
  logic                  ld1, lanes_ready;
  logic [CNT_W-1:0]      range_count;
  logic                  hit_valid, hit_ready;
  logic [MAX_RANGES-1:0] hit;
  logic                  matched;

  always_comb begin
    in_item.command     = cmd_e'(s_axis_tuser_i[0]);
    in_item.entry_index = s_axis_tdata_i[IDX_W-1:0];
    in_item.range_low   = s_axis_tdata_i[IDX_W +: ADDR_W];
    in_item.range_high  = s_axis_tdata_i[IDX_W+ADDR_W +: ADDR_W];
    in_item.address     = s_axis_tdata_i[IDX_W+2*ADDR_W +: ADDR_W];
  end

  assign ld1             = ~v1_q | lanes_ready;
  assign s_axis_tready_o = ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ld1) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      item_q <= in_item;
    end
  end

  irgm_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .range_count_o (range_count)
  );

  irgm_lanes #(
    .MAX_RANGES (MAX_RANGES)
  ) u_lanes (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (v1_q),
    .in_ready_o    (lanes_ready),
    .in_item_i     (item_q),
    .range_count_i (range_count),
    .hit_valid_o   (hit_valid),
    .hit_ready_i   (hit_ready),
    .hit_o         (hit)
  );

  irgm_reduce #(
    .MAX_RANGES (MAX_RANGES)
  ) u_reduce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hit_valid_i   (hit_valid),
    .hit_ready_o   (hit_ready),
    .hit_i         (hit),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_matched_o (matched)
  );

  assign m_axis_tdata_o = M_TDATA_W'(matched);

endmodule
